[rtl/epoch_to_civil_date_time_defines.svh]
// Assertion macros used by the checker file of the epoch to civil date block.
// Depends on nothing; the using module supplies clk_i and rst_ni.
`ifndef EPOCH_TO_CIVIL_DATE_TIME_DEFINES_SVH
`define EPOCH_TO_CIVIL_DATE_TIME_DEFINES_SVH

// same-cycle implication
`define ECTD_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ECTD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ectd_pkg.sv]
// Shared constants, types and tables of the epoch to civil date/time block.
// No dependencies.
package ectd_pkg;

  localparam int NUM_STAGES = 10;
  localparam int DAY_STAGES = 3;
  localparam int CIV_STAGES = NUM_STAGES - DAY_STAGES;

  localparam int EPOCH_W = 32;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int WDAY_W  = 3;
  localparam int YEAR_W  = 8;
  localparam int MON_W   = 4;
  localparam int MDAY_W  = 5;

  localparam int DAY_NUM_W = 16;
  localparam int SOD_W     = 17;

  // seconds split: offset so that (epoch + 2^31 + bias) / 86400 = days + 24856
  localparam int EPOCH_BIAS = 74752;
  localparam int DAY_DIV_HI = 675;        // 86400 = 675 * 128
  localparam int RECIP_675  = 6362914;    // floor(2^32 / 675)

  localparam int HOUR_RECIP = 4661;       // /225 at 2^20
  localparam int SECS_HOUR  = 3600;
  localparam int MIN_RECIP  = 1093;       // /15 at 2^14
  localparam int SECS_MIN   = 60;
  localparam int WDAY_BIAS  = 5;
  localparam int RECIP_7    = 74899;      // /7 at 2^19

  localparam int DAY_BASE   = 694612;     // 719468 - 24856
  localparam int ERA_DAYS   = 146097;
  localparam int ERA5_START = 5 * ERA_DAYS;
  localparam int ERA4_START = 4 * ERA_DAYS;
  localparam int RECIP_365  = 45965;      // /365 at 2^24
  localparam int CENT_DAYS  = 36524;
  localparam int RECIP_153  = 1714;       // /153 at 2^18
  localparam int YEAR_OFS_ERA5 = 100;     // 2000 - 1900
  localparam int YEAR_OFS_ERA4 = 724;     // 1600 - 1900, mod 1024

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [WDAY_W-1:0] weekday;
  } tod_t;

  // first day-of-year of each month of a March-based year
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    unique case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

[rtl/ectd_req_if.sv]
// Request channel carrying a signed Unix epoch in seconds.
// Depends on ectd_pkg.
interface ectd_req_if import ectd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [EPOCH_W-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

[rtl/ectd_res_if.sv]
// Result channel carrying the broken-down UTC date and time.
// Depends on ectd_pkg.
interface ectd_res_if import ectd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HOUR_W-1:0] hour_of_day;
  logic [MIN_W-1:0]  minute_of_hour;
  logic [SEC_W-1:0]  seconds_of_minute;
  logic [WDAY_W-1:0] weekday;
  logic [YEAR_W-1:0] year_since_1900;
  logic [MON_W-1:0]  month_index;
  logic [MDAY_W-1:0] day_of_month;

  modport source (output valid, output hour_of_day, output minute_of_hour,
                  output seconds_of_minute, output weekday, output year_since_1900,
                  output month_index, output day_of_month, input ready);
  modport sink   (input valid, input hour_of_day, input minute_of_hour,
                  input seconds_of_minute, input weekday, input year_since_1900,
                  input month_index, input day_of_month, output ready);
endinterface

[rtl/ectd_day_split.sv]
// Three-stage floor split of epoch seconds into a biased day number and second of day.
// Depends on ectd_pkg.
module ectd_day_split import ectd_pkg::*; (
  input  logic                        clk_i,
  input  logic [DAY_STAGES-1:0]       en_i,
  input  logic signed [EPOCH_W-1:0]   epoch_seconds_i,
  output logic [DAY_NUM_W-1:0]        day_num_o,
  output logic [SOD_W-1:0]            sod_o
);

  logic [EPOCH_W:0]       v_d, v_q;
  logic [48:0]            prod;
  logic [DAY_NUM_W-1:0]   q0_d, q0_q;
  logic [25:0]            w_d, w_q;
  logic [6:0]             vlo_d, vlo_q;
  logic [25:0]            rem_full;
  logic                   rem_ge;
  logic [9:0]             rem_d;
  logic [DAY_NUM_W-1:0]   day_d, day_q;
  logic [SOD_W-1:0]       sod_d, sod_q;

  // offset binary, biased so the quotient stays non-negative
  assign v_d = {1'b0, ~epoch_seconds_i[EPOCH_W-1], epoch_seconds_i[EPOCH_W-2:0]}
             + (EPOCH_W+1)'(EPOCH_BIAS);

  assign w_d   = v_q[EPOCH_W:7];
  assign vlo_d = v_q[6:0];
  assign prod  = 49'(w_d) * 49'(RECIP_675);
  assign q0_d  = prod[47:32];

  // estimate is low by at most one
  assign rem_full = w_q - 26'(q0_q) * 26'(DAY_DIV_HI);
  assign rem_ge   = rem_full >= 26'(DAY_DIV_HI);
  assign day_d    = rem_ge ? q0_q + DAY_NUM_W'(1) : q0_q;
  assign rem_d    = rem_ge ? 10'(rem_full - 26'(DAY_DIV_HI)) : rem_full[9:0];
  assign sod_d    = {rem_d, vlo_q};

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      v_q <= v_d;
    end
    if (en_i[1]) begin
      q0_q  <= q0_d;
      w_q   <= w_d;
      vlo_q <= vlo_d;
    end
    if (en_i[2]) begin
      day_q <= day_d;
      sod_q <= sod_d;
    end
  end

  assign day_num_o = day_q;
  assign sod_o     = sod_q;

endmodule

[rtl/ectd_civil.sv]
// Seven-stage civil-from-days pipeline: biased day number to year, month and day.
// Depends on ectd_pkg.
module ectd_civil import ectd_pkg::*; (
  input  logic                  clk_i,
  input  logic [CIV_STAGES-1:0] en_i,
  input  logic [DAY_NUM_W-1:0]  day_num_i,
  output logic [YEAR_W-1:0]     year_o,
  output logic [MON_W-1:0]      month_o,
  output logic [MDAY_W-1:0]     mday_o
);

  // stage 0: era and day of era
  logic [19:0] shifted;
  logic        era5_d;
  logic [17:0] doe_d;
  logic [17:0] doe0_q, doe1_q, doe2_q, doe3_q;
  logic        era0_q, era1_q, era2_q, era3_q, era4_q, era5_q;

  // stage 1: leap corrections
  logic [31:0] p1460;
  logic [6:0]  d1460_d, d1460_q;
  logic [2:0]  dcent_d, dcent_q;
  logic        dlast_d, dlast_q;

  // stage 2
  logic [17:0] t_d, t_q;

  // stage 3
  logic [33:0] pyoe;
  logic [8:0]  yoe_d, yoe3_q, yoe4_q, yoe5_q;

  // stage 4
  logic [1:0]  cent;
  logic [17:0] ystart;
  logic [17:0] doy_full;
  logic [8:0]  doy4_q, doy5_q;

  // stage 5
  logic [10:0] k5;
  logic [21:0] pmp;
  logic [3:0]  mp_d, mp_q;

  // stage 6
  logic        jan_feb;
  logic [9:0]  yr_full;
  logic [8:0]  md_full;
  logic [YEAR_W-1:0] year_q;
  logic [MON_W-1:0]  month_d, month_q;
  logic [MDAY_W-1:0] mday_q;

  assign shifted = 20'(day_num_i) + 20'(DAY_BASE);
  assign era5_d  = shifted >= 20'(ERA5_START);
  assign doe_d   = 18'(shifted - (era5_d ? 20'(ERA5_START) : 20'(ERA4_START)));

  assign p1460   = 32'(doe0_q[17:2]) * 32'(RECIP_365);
  assign d1460_d = p1460[30:24];
  assign dcent_d = 3'(doe0_q >= 18'(CENT_DAYS)) + 3'(doe0_q >= 18'(2 * CENT_DAYS))
                 + 3'(doe0_q >= 18'(3 * CENT_DAYS)) + 3'(doe0_q >= 18'(4 * CENT_DAYS));
  assign dlast_d = doe0_q == 18'(ERA_DAYS - 1);

  assign t_d = doe1_q - 18'(d1460_q) + 18'(dcent_q) - 18'(dlast_q);

  assign pyoe  = 34'(t_q) * 34'(RECIP_365);
  assign yoe_d = pyoe[32:24];

  always_comb begin
    priority if (yoe3_q >= 9'd300) begin
      cent = 2'd3;
    end else if (yoe3_q >= 9'd200) begin
      cent = 2'd2;
    end else if (yoe3_q >= 9'd100) begin
      cent = 2'd1;
    end else begin
      cent = 2'd0;
    end
  end
  assign ystart   = 18'(yoe3_q) * 18'd365 + 18'(yoe3_q[8:2]) - 18'(cent);
  assign doy_full = doe3_q - ystart;

  assign k5   = 11'(doy4_q) * 11'd5 + 11'd2;
  assign pmp  = 22'(k5) * 22'(RECIP_153);
  assign mp_d = pmp[21:18];

  assign jan_feb = mp_q >= 4'd10;
  assign month_d = jan_feb ? mp_q - 4'd10 : mp_q + 4'd2;
  assign yr_full = 10'(yoe5_q) + (era5_q ? 10'(YEAR_OFS_ERA5) : 10'(YEAR_OFS_ERA4))
                 + 10'(jan_feb);
  assign md_full = doy5_q - month_start(mp_q) + 9'd1;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      doe0_q <= doe_d;
      era0_q <= era5_d;
    end
    if (en_i[1]) begin
      doe1_q  <= doe0_q;
      era1_q  <= era0_q;
      d1460_q <= d1460_d;
      dcent_q <= dcent_d;
      dlast_q <= dlast_d;
    end
    if (en_i[2]) begin
      t_q    <= t_d;
      doe2_q <= doe1_q;
      era2_q <= era1_q;
    end
    if (en_i[3]) begin
      yoe3_q <= yoe_d;
      doe3_q <= doe2_q;
      era3_q <= era2_q;
    end
    if (en_i[4]) begin
      doy4_q <= doy_full[8:0];
      yoe4_q <= yoe3_q;
      era4_q <= era3_q;
    end
    if (en_i[5]) begin
      mp_q   <= mp_d;
      doy5_q <= doy4_q;
      yoe5_q <= yoe4_q;
      era5_q <= era4_q;
    end
    if (en_i[6]) begin
      year_q  <= yr_full[YEAR_W-1:0];
      month_q <= month_d;
      mday_q  <= md_full[MDAY_W-1:0];
    end
  end

  assign year_o  = year_q;
  assign month_o = month_q;
  assign mday_o  = mday_q;

endmodule

[rtl/epoch_to_civil_date_time.sv]
// Unix epoch seconds to UTC calendar date and time of day.
// Depends on ectd_pkg, ectd_req_if, ectd_res_if, ectd_day_split, ectd_civil.
//
// Usage:
//   req_i carries one signed 32-bit epoch_seconds per request; res_o returns
//   hour, minute, second, weekday (Sunday 0), year - 1900, month (January 0)
//   and day of month. Both channels use valid/ready; a transfer happens on a
//   rising edge with both high.
//   Throughput: one request per cycle while res_o is ready; the pipeline
//   has ten stages with one register per stage.
//   Each stage advances when it is empty or the stage after it advances, so
//   while res_o is held off, empty stages still fill and req_i.ready only
//   drops once every stage holds a request.
//   Reset (rst_ni low, asynchronous) empties the pipeline; data registers
//   are not cleared. A held result keeps its payload stable until taken.
module epoch_to_civil_date_time import ectd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  ectd_req_if.sink          req_i,
  ectd_res_if.source        res_o
);

  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES:0]   en;

  logic [DAY_NUM_W-1:0]  day_num;
  logic [SOD_W-1:0]      sod;

  // time of day / weekday
  logic [25:0]           hp;
  logic [32:0]           q7p;
  logic [DAY_NUM_W-1:0]  x_d;
  logic [HOUR_W-1:0]     hour3_q, hour4_q, hour5_q;
  logic [SOD_W-1:0]      sod3_q;
  logic [DAY_NUM_W-1:0]  x3_q;
  logic [13:0]           q7_3_q;
  logic [SOD_W-1:0]      remh_full;
  logic [DAY_NUM_W-1:0]  wd_full;
  logic [11:0]           remh4_q, remh5_q;
  logic [WDAY_W-1:0]     wd4_q, wd5_q;
  logic [20:0]           pmn;
  logic [MIN_W-1:0]      mn5_q;
  logic [11:0]           sec_full;
  tod_t                  tod_d;
  tod_t                  tod_q [4];

  logic [YEAR_W-1:0]     year;
  logic [MON_W-1:0]      month;
  logic [MDAY_W-1:0]     mday;

  always_comb begin
    en[NUM_STAGES] = res_o.ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= req_i.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign req_i.ready = en[0];
  assign res_o.valid = vld_q[NUM_STAGES-1];

  ectd_day_split u_day_split (
    .clk_i           (clk_i),
    .en_i            (en[DAY_STAGES-1:0]),
    .epoch_seconds_i (req_i.epoch_seconds),
    .day_num_o       (day_num),
    .sod_o           (sod)
  );

  ectd_civil u_civil (
    .clk_i     (clk_i),
    .en_i      (en[NUM_STAGES-1:DAY_STAGES]),
    .day_num_i (day_num),
    .year_o    (year),
    .month_o   (month),
    .mday_o    (mday)
  );

  assign hp  = 26'(sod[SOD_W-1:4]) * 26'(HOUR_RECIP);
  assign x_d = day_num + DAY_NUM_W'(WDAY_BIAS);
  assign q7p = 33'(x_d) * 33'(RECIP_7);

  assign remh_full = sod3_q - SOD_W'(hour3_q) * SOD_W'(SECS_HOUR);
  assign wd_full   = x3_q - DAY_NUM_W'(q7_3_q) * DAY_NUM_W'(7);

  assign pmn      = 21'(remh4_q[11:2]) * 21'(MIN_RECIP);
  assign sec_full = remh5_q - 12'(mn5_q) * 12'(SECS_MIN);

  assign tod_d = '{hour: hour5_q, minute: mn5_q, second: sec_full[SEC_W-1:0],
                   weekday: wd5_q};

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      hour3_q <= hp[24:20];
      sod3_q  <= sod;
      x3_q    <= x_d;
      q7_3_q  <= q7p[32:19];
    end
    if (en[4]) begin
      hour4_q <= hour3_q;
      remh4_q <= remh_full[11:0];
      wd4_q   <= wd_full[WDAY_W-1:0];
    end
    if (en[5]) begin
      hour5_q <= hour4_q;
      remh5_q <= remh4_q;
      wd5_q   <= wd4_q;
      mn5_q   <= pmn[19:14];
    end
    if (en[6]) begin
      tod_q[0] <= tod_d;
    end
    for (int k = 1; k < 4; k++) begin
      if (en[6+k]) begin
        tod_q[k] <= tod_q[k-1];
      end
    end
  end

  assign res_o.hour_of_day       = tod_q[3].hour;
  assign res_o.minute_of_hour    = tod_q[3].minute;
  assign res_o.seconds_of_minute = tod_q[3].second;
  assign res_o.weekday           = tod_q[3].weekday;
  assign res_o.year_since_1900   = year;
  assign res_o.month_index       = month;
  assign res_o.day_of_month      = mday;

endmodule

[rtl/ectd_checker.sv]
// Port-level checks of epoch_to_civil_date_time, bound to the top level.
// Depends on ectd_pkg and epoch_to_civil_date_time_defines.svh.
`include "epoch_to_civil_date_time_defines.svh"

module ectd_checker import ectd_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input logic [HOUR_W-1:0] hour_i,
  input logic [MIN_W-1:0]  minute_i,
  input logic [SEC_W-1:0]  second_i,
  input logic [WDAY_W-1:0] weekday_i,
  input logic [YEAR_W-1:0] year_i,
  input logic [MON_W-1:0]  month_i,
  input logic [MDAY_W-1:0] mday_i
);

  localparam int CntW = $clog2(NUM_STAGES + 1);

  logic [CntW-1:0] cnt_d, cnt_q;
  logic            req_acc, res_acc;

  assign req_acc = req_valid_i && req_ready_i;
  assign res_acc = res_valid_i && res_ready_i;
  assign cnt_d   = cnt_q + CntW'(req_acc) - CntW'(res_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `ECTD_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i,
    res_valid_i && $stable(hour_i) && $stable(minute_i) && $stable(second_i) &&
    $stable(weekday_i) && $stable(year_i) && $stable(month_i) && $stable(mday_i),
    "result changed while stalled")
  `ECTD_ASSERT_IMPL(a_no_phantom, res_valid_i, cnt_q != '0,
    "result without an outstanding request")
  `ECTD_ASSERT_IMPL(a_full_stall, (cnt_q == CntW'(NUM_STAGES)) && !res_ready_i,
    !req_ready_i, "request taken with a full, stalled pipeline")
  `ECTD_ASSERT_IMPL(a_ranges, res_valid_i,
    hour_i < 5'd24 && minute_i < 6'd60 && second_i < 6'd60 && weekday_i < 3'd7 &&
    month_i < 4'd12 && mday_i != 5'd0 && year_i != 8'd0 && year_i < 8'd139,
    "result field out of range")

endmodule

bind epoch_to_civil_date_time ectd_checker u_ectd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .hour_i      (res_o.hour_of_day),
  .minute_i    (res_o.minute_of_hour),
  .second_i    (res_o.seconds_of_minute),
  .weekday_i   (res_o.weekday),
  .year_i      (res_o.year_since_1900),
  .month_i     (res_o.month_index),
  .mday_i      (res_o.day_of_month)
);
